>>> sv/plds_pkg.sv
// Shared types, widths and saturating arithmetic for the packet loss/delay statistics block.
`timescale 1ns / 1ps

package plds_pkg;

	localparam int SEQ_W  = 48;
	localparam int TIME_W = 52;
	localparam int CNT_W  = 32;
	localparam int ACC_W  = 64;

	typedef struct packed {
		logic              is_end;
		logic [SEQ_W-1:0]  seq_number;
		logic [TIME_W-1:0] send_time;
		logic [TIME_W-1:0] recv_time;
	} plds_in_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  lost_packets;
		logic [SEQ_W-1:0]  expected_packets;
		logic [CNT_W-1:0]  record_count;
		logic [ACC_W-1:0]  sum_interarrival;
		logic [ACC_W-1:0]  sum_delay;
		logic [ACC_W-1:0]  sumsq_interarrival;
		logic [ACC_W-1:0]  sumsq_delay;
		logic [TIME_W-1:0] first_send_time;
		logic [TIME_W-1:0] last_recv_time;
	} plds_out_t;

	function automatic logic [SEQ_W-1:0] sat_add_seq(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
		logic [SEQ_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SEQ_W] ? {SEQ_W{1'b1}} : s[SEQ_W-1:0];
	endfunction

	function automatic logic [ACC_W-1:0] sat_add_u(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
	endfunction

	// two's complement add, clamped at both ends
	function automatic logic [ACC_W-1:0] sat_add_s(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
		logic [ACC_W-1:0] s;
		s = a + b;
		if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
			return a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return s;
	endfunction

endpackage

>>> sv/plds_pair_calc.sv
// Inter-arrival and one-way delay of a record pair, clamped to DIFF_BITS.
`timescale 1ns / 1ps

module plds_pair_calc #(
	parameter int DIFF_BITS = 32
) (
	input  logic [plds_pkg::TIME_W-1:0] recv_time,
	input  logic [plds_pkg::TIME_W-1:0] prev_recv,
	input  logic [plds_pkg::TIME_W-1:0] prev_send,
	output logic [DIFF_BITS-1:0]        iarr,
	output logic [DIFF_BITS-1:0]        dly,
	output logic [DIFF_BITS-1:0]        mag
);
	import plds_pkg::*;

	localparam logic [DIFF_BITS-1:0] SMAX = {1'b0, {(DIFF_BITS-1){1'b1}}};
	localparam logic [DIFF_BITS-1:0] SMIN = {1'b1, {(DIFF_BITS-1){1'b0}}};

	logic [TIME_W-1:0] iarr_raw;
	logic              recv_back;
	logic [TIME_W:0]   d;
	logic [TIME_W:0]   d_neg;
	logic              pos_ovf;
	logic              neg_ovf;
	logic              neg_big;

	assign iarr_raw  = recv_time - prev_recv;
	assign recv_back = recv_time < prev_recv;
	assign d         = {1'b0, prev_recv} - {1'b0, prev_send};
	assign d_neg     = {1'b0, prev_send} - {1'b0, prev_recv};
	assign pos_ovf   = !d[TIME_W] && (|d[TIME_W-1:DIFF_BITS-1]);
	assign neg_ovf   = d[TIME_W] && !(&d[TIME_W-1:DIFF_BITS-1]);
	assign neg_big   = |d_neg[TIME_W:DIFF_BITS-1];

	always_comb begin
		if (recv_back) begin
			iarr = '0;
		end else if (|iarr_raw[TIME_W-1:DIFF_BITS]) begin
			iarr = '1;
		end else begin
			iarr = iarr_raw[DIFF_BITS-1:0];
		end

		if (pos_ovf) begin
			dly = SMAX;
		end else if (neg_ovf) begin
			dly = SMIN;
		end else begin
			dly = d[DIFF_BITS-1:0];
		end

		// magnitude taken from the side that is positive, so no negate follows the clamp
		if (d[TIME_W]) begin
			mag = neg_big ? SMIN : d_neg[DIFF_BITS-1:0];
		end else begin
			mag = pos_ovf ? SMAX : d[DIFF_BITS-1:0];
		end
	end

endmodule

>>> sv/packet_loss_delay_statistics_top.sv
// Top level of the packet loss and delay statistics accumulator.
// Throughput: one record per cycle while no end record waits in s3 for a busy result
// register; records pass stages s1 (pairing), s2 (counters, squares) and s3 (moment
// sums) in order, and an end record leaves s3 only into a free result register.
// Reset (arst_n low) clears all counters, sums and pairing state and empties the
// pipeline; an end record clears them again for the next session.
`timescale 1ns / 1ps

module packet_loss_delay_statistics_top #(
	parameter int DIFF_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	output logic                rec_stall,
	input  plds_pkg::plds_in_t  rec,
	output logic                stat_valid,
	input  logic                stat_stall,
	output plds_pkg::plds_out_t stat
);
	import plds_pkg::*;

	// ---------------- pipeline control ----------------
	// Each stage takes a new request when it is empty or emptying. Non-end records
	// retire out of s3 on their own; only an end record needs the result register.
	logic valid_s1, valid_s2, valid_s3;
	logic stat_valid_q;
	logic out_free, adv_s1, adv_s2, adv_s3;
	logic take_s2, take_s3, rec_acc;

	logic end_s3;

	assign out_free  = !stat_valid_q || !stat_stall;
	assign adv_s3    = valid_s3 && (!end_s3 || out_free);
	assign take_s3   = !valid_s3 || adv_s3;
	assign adv_s2    = valid_s2 && take_s3;
	assign take_s2   = !valid_s2 || adv_s2;
	assign adv_s1    = valid_s1 && take_s2;
	assign rec_stall = valid_s1 && !take_s2;
	assign rec_acc   = rec_valid && !rec_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rec_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s3 <= 1'b1;
			end else if (adv_s3) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	// ---------------- s1: input register and pairing ----------------
	plds_in_t rec_s1;

	always_ff @(posedge clk) begin
		if (rec_acc) begin
			rec_s1 <= rec;
		end
	end

	logic              have_prev_q;
	logic [SEQ_W-1:0]  prev_seq_q;
	logic [TIME_W-1:0] prev_send_q;
	logic [TIME_W-1:0] prev_recv_q;
	logic [TIME_W-1:0] first_send_q;

	logic [SEQ_W-1:0]     gap;
	logic                 gap_big;
	logic [DIFF_BITS-1:0] iarr_c, dly_c, mag_c;

	assign gap     = rec_s1.seq_number - prev_seq_q;
	assign gap_big = gap > SEQ_W'(1);

	plds_pair_calc #(
		.DIFF_BITS(DIFF_BITS)
	) u_pair_calc (
		.recv_time(rec_s1.recv_time),
		.prev_recv(prev_recv_q),
		.prev_send(prev_send_q),
		.iarr     (iarr_c),
		.dly      (dly_c),
		.mag      (mag_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q  <= 1'b0;
			prev_seq_q   <= '0;
			prev_send_q  <= '0;
			prev_recv_q  <= '0;
			first_send_q <= '0;
		end else if (adv_s1) begin
			if (rec_s1.is_end) begin
				have_prev_q  <= 1'b0;
				prev_seq_q   <= '0;
				prev_send_q  <= '0;
				prev_recv_q  <= '0;
				first_send_q <= '0;
			end else begin
				have_prev_q <= 1'b1;
				prev_seq_q  <= rec_s1.seq_number;
				prev_send_q <= rec_s1.send_time;
				prev_recv_q <= rec_s1.recv_time;
				if (!have_prev_q) begin
					first_send_q <= rec_s1.send_time;
				end
			end
		end
	end

	// s2 payload: per-record increments plus the session's time snapshots
	logic                 end_s2, pair_s2, cnt_inc_s2;
	logic [SEQ_W-1:0]     lost_inc_s2, exp_inc_s2;
	logic [DIFF_BITS-1:0] iarr_s2, dly_s2, mag_s2;
	logic [TIME_W-1:0]    first_s2, last_s2;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			end_s2     <= rec_s1.is_end;
			cnt_inc_s2 <= !rec_s1.is_end;
			pair_s2    <= !rec_s1.is_end && have_prev_q && !gap_big;
			iarr_s2    <= iarr_c;
			dly_s2     <= dly_c;
			mag_s2     <= mag_c;
			first_s2   <= first_send_q;
			last_s2    <= prev_recv_q;
			if (rec_s1.is_end || !have_prev_q) begin
				lost_inc_s2 <= '0;
				exp_inc_s2  <= '0;
			end else if (gap_big) begin
				lost_inc_s2 <= gap - SEQ_W'(1);
				exp_inc_s2  <= gap;
			end else begin
				lost_inc_s2 <= '0;
				exp_inc_s2  <= SEQ_W'(1);
			end
		end
	end

	// ---------------- s2: packet counters and squares ----------------
	logic [SEQ_W-1:0] lost_q, exp_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_q  <= '0;
			exp_q   <= '0;
			count_q <= '0;
		end else if (adv_s2) begin
			if (end_s2) begin
				lost_q  <= '0;
				exp_q   <= '0;
				count_q <= '0;
			end else begin
				lost_q <= sat_add_seq(lost_q, lost_inc_s2);
				exp_q  <= sat_add_seq(exp_q, exp_inc_s2);
				if (cnt_inc_s2 && !(&count_q)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	logic [2*DIFF_BITS-1:0] sq_iarr_c, sq_mag_c;

	assign sq_iarr_c = iarr_s2 * iarr_s2;
	assign sq_mag_c  = mag_s2 * mag_s2;

	logic                 pair_s3;
	logic [DIFF_BITS-1:0] iarr_s3, dly_s3;
	logic [ACC_W-1:0]     sq_iarr_s3, sq_mag_s3;
	logic [SEQ_W-1:0]     lost_s3, exp_s3;
	logic [CNT_W-1:0]     count_s3;
	logic [TIME_W-1:0]    first_s3, last_s3;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			end_s3     <= end_s2;
			pair_s3    <= pair_s2;
			iarr_s3    <= iarr_s2;
			dly_s3     <= dly_s2;
			sq_iarr_s3 <= ACC_W'(sq_iarr_c);
			sq_mag_s3  <= ACC_W'(sq_mag_c);
			lost_s3    <= lost_q;
			exp_s3     <= exp_q;
			count_s3   <= count_q;
			first_s3   <= first_s2;
			last_s3    <= last_s2;
		end
	end

	// ---------------- s3: moment sums and result register ----------------
	logic [ACC_W-1:0] iarr_sum_q, dly_sum_q, iarr_sq_q, dly_sq_q;
	logic [ACC_W-1:0] iarr_ext, dly_ext;

	assign iarr_ext = ACC_W'(iarr_s3);
	assign dly_ext  = {{(ACC_W-DIFF_BITS){dly_s3[DIFF_BITS-1]}}, dly_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iarr_sum_q <= '0;
			dly_sum_q  <= '0;
			iarr_sq_q  <= '0;
			dly_sq_q   <= '0;
		end else if (adv_s3) begin
			if (end_s3) begin
				iarr_sum_q <= '0;
				dly_sum_q  <= '0;
				iarr_sq_q  <= '0;
				dly_sq_q   <= '0;
			end else if (pair_s3) begin
				iarr_sum_q <= sat_add_u(iarr_sum_q, iarr_ext);
				dly_sum_q  <= sat_add_s(dly_sum_q, dly_ext);
				iarr_sq_q  <= sat_add_u(iarr_sq_q, sq_iarr_s3);
				dly_sq_q   <= sat_add_u(dly_sq_q, sq_mag_s3);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_valid_q <= 1'b0;
		end else if (adv_s3 && end_s3) begin
			stat_valid_q <= 1'b1;
		end else if (!stat_stall) begin
			stat_valid_q <= 1'b0;
		end
	end

	plds_out_t stat_q;

	always_ff @(posedge clk) begin
		if (adv_s3 && end_s3) begin
			stat_q.lost_packets       <= lost_s3;
			stat_q.expected_packets   <= exp_s3;
			stat_q.record_count       <= count_s3;
			stat_q.sum_interarrival   <= iarr_sum_q;
			stat_q.sum_delay          <= dly_sum_q;
			stat_q.sumsq_interarrival <= iarr_sq_q;
			stat_q.sumsq_delay        <= dly_sq_q;
			stat_q.first_send_time    <= first_s3;
			stat_q.last_recv_time     <= last_s3;
		end
	end

	assign stat_valid = stat_valid_q;
	assign stat       = stat_q;

	// ---------------- checks ----------------
`ifndef ASSERT_OFF
	// an empty input stage never holds off a request
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !rec_stall)
		else $error("input stalled with empty s1");

	// every gap adds gap-1 to lost and gap to expected, so lost never passes expected
	a_lost_le_expected: assert property (@(posedge clk) disable iff (!arst_n)
		lost_q <= exp_q)
		else $error("lost count above expected count");

	// an end record leaving s1 clears the pairing state
	a_end_clears_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && rec_s1.is_end) |=> !have_prev_q && first_send_q == '0)
		else $error("pairing state not cleared by end record");

	// an end record leaving s3 always lands in the result register
	a_end_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && end_s3) |=> stat_valid)
		else $error("end record lost before result register");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the packet loss and delay statistics accumulator.
`timescale 1ns / 1ps

module tb;
	import plds_pkg::*;

	localparam int DIFF_BITS    = 32;
	localparam int STALL_LIMIT  = 3000;  // cycles with no transfer before giving up
	localparam int HOLD_CYCLES  = 400;   // one long receiver hold-off
	localparam int DRAIN_CYCLES = 10;    // pipeline is 3 deep, allow some margin
	localparam int RANDOM_RECS  = 1500;
	localparam int MAX_REPORTS  = 10;
	localparam int IDLE_PCT     = 8;

	localparam logic [SEQ_W-1:0]  SEQ_MAX  = '1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [ACC_W-1:0]  SEQ_CAP  = {{(ACC_W-SEQ_W){1'b0}}, {SEQ_W{1'b1}}};
	localparam logic [ACC_W-1:0]  CNT_CAP  = {{(ACC_W-CNT_W){1'b0}}, {CNT_W{1'b1}}};
	localparam logic [ACC_W-1:0]  U64_CAP  = '1;
	localparam logic [ACC_W-1:0]  ONE_ACC  = {{(ACC_W-1){1'b0}}, 1'b1};

	logic      clk;
	logic      arst_n;
	logic      rec_valid;
	logic      rec_stall;
	plds_in_t  rec;
	logic      stat_valid;
	logic      stat_stall;
	plds_out_t stat;

	packet_loss_delay_statistics_top #(
		.DIFF_BITS(DIFF_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec(rec),
		.stat_valid(stat_valid),
		.stat_stall(stat_stall),
		.stat(stat)
	);

	// Records waiting to be offered, and statistics results still owed by the block.
	plds_in_t  pending_recs[$];
	plds_out_t stat_expect[$];

	// Session state of the predictor.
	logic                     have_prev;
	logic [SEQ_W-1:0]         last_seq;
	logic [TIME_W-1:0]        last_send;
	logic [TIME_W-1:0]        last_recv;
	logic [TIME_W-1:0]        sess_first_send;
	logic [SEQ_W-1:0]         lost_sum;
	logic [SEQ_W-1:0]         exp_sum;
	logic [CNT_W-1:0]         rec_cnt;
	logic [ACC_W-1:0]         iarr_sum;
	logic signed [ACC_W-1:0]  dly_sum;
	logic [ACC_W-1:0]         iarr_sq;
	logic [ACC_W-1:0]         dly_sq;

	int   mismatches  = 0;
	int   recs_taken  = 0;
	int   stats_seen  = 0;
	int   idle_cycles = 0;
	int   cyc         = 0;
	int   hold_left   = 0;
	bit   hold_done   = 0;
	logic rec_took    = 1'b0;
	logic calm;

	// Window with no random idling on either side.
	assign calm = (cyc >= 600) && (cyc < 1100);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [ACC_W-1:0] capped_add(input logic [ACC_W-1:0] a,
			input logic [ACC_W-1:0] b, input logic [ACC_W-1:0] cap);
		logic [ACC_W:0] w;
		w = {1'b0, a} + {1'b0, b};
		return (w > {1'b0, cap}) ? cap : w[ACC_W-1:0];
	endfunction

	function automatic logic [SEQ_W-1:0] rand_seq();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[SEQ_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TIME_W-1:0];
	endfunction

	task automatic clear_session();
		have_prev       = 1'b0;
		last_seq        = '0;
		last_send       = '0;
		last_recv       = '0;
		sess_first_send = '0;
		lost_sum        = '0;
		exp_sum         = '0;
		rec_cnt         = '0;
		iarr_sum        = '0;
		dly_sum         = '0;
		iarr_sq         = '0;
		dly_sq          = '0;
	endtask

	// Folds one accepted record into the session; an end record yields the statistics.
	task automatic account_record(input plds_in_t r);
		logic [SEQ_W-1:0]        gap;
		logic [ACC_W-1:0]        iarr;
		logic [ACC_W-1:0]        umax;
		longint                  dly;
		longint                  smax;
		longint                  smin;
		longint unsigned         mag;
		logic [ACC_W:0]          wide;
		plds_out_t               res;
		if (r.is_end) begin
			res.lost_packets       = lost_sum;
			res.expected_packets   = exp_sum;
			res.record_count       = rec_cnt;
			res.sum_interarrival   = iarr_sum;
			res.sum_delay          = dly_sum;
			res.sumsq_interarrival = iarr_sq;
			res.sumsq_delay        = dly_sq;
			res.first_send_time    = sess_first_send;
			res.last_recv_time     = last_recv;
			stat_expect.push_back(res);
			clear_session();
			return;
		end
		rec_cnt = CNT_W'(capped_add(ACC_W'(rec_cnt), ONE_ACC, CNT_CAP));
		if (!have_prev) begin
			sess_first_send = r.send_time;
		end else begin
			gap = r.seq_number - last_seq;
			if (gap > 1) begin
				// loss: backwards jumps land here too, as huge gaps
				lost_sum = SEQ_W'(capped_add(ACC_W'(lost_sum), ACC_W'(gap - 1), SEQ_CAP));
				exp_sum  = SEQ_W'(capped_add(ACC_W'(exp_sum), ACC_W'(gap), SEQ_CAP));
			end else begin
				exp_sum = SEQ_W'(capped_add(ACC_W'(exp_sum), ONE_ACC, SEQ_CAP));
				umax = (64'd1 << DIFF_BITS) - 1;
				iarr = (r.recv_time >= last_recv) ? ACC_W'(r.recv_time - last_recv) : '0;
				if (iarr > umax) begin
					iarr = umax;
				end
				// delay of the earlier record, clamped to a DIFF_BITS signed value
				smax = (longint'(1) <<< (DIFF_BITS - 1)) - 1;
				smin = -smax - 1;
				dly  = longint'({12'b0, last_recv}) - longint'({12'b0, last_send});
				if (dly > smax) begin
					dly = smax;
				end
				if (dly < smin) begin
					dly = smin;
				end
				mag  = (dly < 0) ? longint'(-dly) : dly;
				wide = {dly_sum[ACC_W-1], dly_sum} + {dly[63], dly};
				if (wide[ACC_W] != wide[ACC_W-1]) begin
					dly_sum = wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
				end else begin
					dly_sum = wide[ACC_W-1:0];
				end
				iarr_sum = capped_add(iarr_sum, iarr, U64_CAP);
				iarr_sq  = capped_add(iarr_sq, iarr * iarr, U64_CAP);
				dly_sq   = capped_add(dly_sq, mag * mag, U64_CAP);
			end
		end
		have_prev = 1'b1;
		last_seq  = r.seq_number;
		last_send = r.send_time;
		last_recv = r.recv_time;
	endtask

	task automatic check_field(input string fname, input logic [ACC_W-1:0] got,
			input logic [ACC_W-1:0] want);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("%s mismatch: expected %h, got %h", fname, want, got);
			end
		end
	endtask

	task automatic push_rec(input logic is_end, input logic [SEQ_W-1:0] seq,
			input logic [TIME_W-1:0] snd, input logic [TIME_W-1:0] rcv);
		plds_in_t r;
		r.is_end     = is_end;
		r.seq_number = seq;
		r.send_time  = snd;
		r.recv_time  = rcv;
		pending_recs.push_back(r);
	endtask

	// One session: mostly in-order records with realistic timing, some loss, duplicates,
	// reordering and jitter, a little pure noise, then the end request.
	task automatic queue_session(input int n_recs);
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] rcv;
		int                pick;
		seq = ($urandom_range(99) < 70) ? rand_seq() : SEQ_W'($urandom_range(1000));
		t   = ($urandom_range(99) < 70) ? rand_time() : TIME_W'($urandom_range(100000));
		for (int i = 0; i < n_recs; i++) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				seq = seq + 1;
			end else if (pick < 84) begin
				// duplicate: sequence stays
			end else if (pick < 94) begin
				seq = seq + SEQ_W'($urandom_range(2, 20));
			end else if (pick < 97) begin
				seq = seq - SEQ_W'($urandom_range(1, 5));
			end else begin
				seq = rand_seq();
			end
			t = ($urandom_range(99) < 2) ? rand_time() : t + TIME_W'($urandom_range(1, 500));
			pick = $urandom_range(99);
			if (pick < 90) begin
				rcv = t + TIME_W'($urandom_range(3000));
			end else if (pick < 96) begin
				rcv = t - TIME_W'($urandom_range(1, 3000));
			end else begin
				rcv = rand_time();
			end
			if ($urandom_range(99) < 3) begin
				push_rec(1'b0, rand_seq(), rand_time(), rand_time());
			end else begin
				push_rec(1'b0, seq, t, rcv);
			end
		end
		push_rec(1'b1, rand_seq(), rand_time(), rand_time());
	endtask

	task automatic wait_drained();
		while (pending_recs.size() != 0 || rec_valid || stat_expect.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Stimulus: directed corner sessions, then random sessions in two halves with a
	// full drain of the block between them.
	initial begin
		int queued;
		int len;
		rec_valid  = 1'b0;
		rec        = '0;
		stat_stall = 1'b0;
		arst_n     = 1'b0;
		clear_session();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// end request on an empty session: all zeros, ignored fields all ones
		push_rec(1'b1, SEQ_MAX, TIME_MAX, TIME_MAX);
		// extreme timing: wrap of sequence, receive time going backwards, clamped
		// inter-arrival and delay in both directions, squares saturating
		push_rec(1'b0, SEQ_MAX, '0, TIME_MAX);
		push_rec(1'b0, '0, TIME_MAX, '0);
		push_rec(1'b0, 1, '0, TIME_MAX);
		push_rec(1'b0, 1, TIME_MAX, TIME_MAX);  // duplicate sequence number
		push_rec(1'b0, 2, TIME_MAX, '0);
		push_rec(1'b0, 3, '0, TIME_MAX);
		push_rec(1'b0, 4, TIME_MAX, '0);
		push_rec(1'b0, 5, '0, TIME_MAX);
		// sequence going backwards twice: loss counters saturate
		push_rec(1'b0, 2, '0, '0);
		push_rec(1'b0, '0, '0, '0);
		push_rec(1'b0, 1000, rand_time(), rand_time());
		push_rec(1'b1, '0, '0, '0);
		// single-record session
		push_rec(1'b0, 77, 123, 456);
		push_rec(1'b1, SEQ_MAX, '0, TIME_MAX);
		// ordinary small session with a late packet and one loss
		push_rec(1'b0, 10, 100, 150);
		push_rec(1'b0, 11, 120, 140);
		push_rec(1'b0, 12, 130, 200);
		push_rec(1'b0, 14, 210, 260);
		push_rec(1'b1, '0, '0, '0);
		wait_drained();

		queued = 0;
		while (queued < RANDOM_RECS) begin
			len = ($urandom_range(99) < 10) ? $urandom_range(41, 120) : $urandom_range(0, 40);
			queue_session(len);
			queued += len + 1;
			if (queued >= RANDOM_RECS / 2 && queued - len - 1 < RANDOM_RECS / 2) begin
				// sender pause: let every owed result come out first
				wait_drained();
			end
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d records and %0d statistics results, %0d field mismatches",
			recs_taken, stats_seen, mismatches);
		$display("receiver hold-off of %0d cycles applied: %0d", HOLD_CYCLES, hold_done);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Sender: a request stays on the bus until taken; idling only between requests.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!rec_valid || rec_took) begin
				if (pending_recs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					rec       <= pending_recs.pop_front();
					rec_valid <= 1'b1;
				end else begin
					rec_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off once some results have come,
	// so that end requests back up and the block has to stall its input.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left  <= hold_left - 1;
				stat_stall <= 1'b1;
			end else if (!hold_done && stats_seen >= 20) begin
				hold_done  <= 1'b1;
				hold_left  <= HOLD_CYCLES - 1;
				stat_stall <= 1'b1;
			end else begin
				stat_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Monitor: predicts on every accepted request, checks every accepted result.
	always @(posedge clk) begin : monitor
		plds_out_t want;
		if (arst_n) begin
			cyc      <= cyc + 1;
			rec_took <= rec_valid && !rec_stall;
			if (rec_valid && !rec_stall) begin
				account_record(rec);
				recs_taken++;
			end
			if (stat_valid && !stat_stall) begin
				stats_seen++;
				if (stat_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("result with nothing expected: %h", stat);
					end
				end else begin
					want = stat_expect.pop_front();
					check_field("lost_packets", stat.lost_packets, want.lost_packets);
					check_field("expected_packets", stat.expected_packets,
						want.expected_packets);
					check_field("record_count", stat.record_count, want.record_count);
					check_field("sum_interarrival", stat.sum_interarrival,
						want.sum_interarrival);
					check_field("sum_delay", stat.sum_delay, want.sum_delay);
					check_field("sumsq_interarrival", stat.sumsq_interarrival,
						want.sumsq_interarrival);
					check_field("sumsq_delay", stat.sumsq_delay, want.sumsq_delay);
					check_field("first_send_time", stat.first_send_time,
						want.first_send_time);
					check_field("last_recv_time", stat.last_recv_time, want.last_recv_time);
				end
			end
		end
	end

	// Watchdog: any transfer on either side restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rec_valid && !rec_stall) || (stat_valid && !stat_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("no transfer for %0d cycles, %0d results still owed",
					STALL_LIMIT, stat_expect.size());
				$display("FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule

>>> filelist.f
sv/plds_pkg.sv
sv/plds_pair_calc.sv
sv/packet_loss_delay_statistics_top.sv
tb/tb.sv
